// ===== rtl/core/fcrc_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame CRC-16 package
// Shared constants, types and the CRC byte update for the frame sealer.
// ----------------------------------------------------------------------------
package fcrc_pkg;

  localparam int FRAME_BYTES    = 24;
  localparam int CRC_FIRST_BYTE = 4;
  localparam int CRC_SPAN       = 18;

  localparam int POS_W    = $clog2(FRAME_BYTES);
  localparam int LO_POS   = FRAME_BYTES - 2;
  localparam int HI_POS   = FRAME_BYTES - 1;
  localparam int SPAN_END = CRC_FIRST_BYTE + CRC_SPAN;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic OP_SEAL  = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  typedef logic [POS_W-1:0] pos_t;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } in_word_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/fcrc_if.sv =====
// ----------------------------------------------------------------------------
// Frame CRC-16 channel interfaces
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface fcrc_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink (input valid, input op, input data_byte, output ready);
endinterface

interface fcrc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic       crc_ok;

  modport source (output valid, output out_byte, output last, output crc_ok, input ready);
  modport sink (input valid, input out_byte, input last, input crc_ok, output ready);
endinterface

// ===== rtl/core/frame_crc16_seal_and_check.sv =====
// ----------------------------------------------------------------------------
// Frame CRC-16 seal and check
// Passes fixed-length frames byte by byte, sealing or checking the CRC-16.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle; the input register and the result register
// form a two-stage pipeline that stalls only when the result is not taken.
// Reset (synchronous, active high) empties the pipeline, sets the CRC to
// 0xFFFF and the frame position to zero.
module frame_crc16_seal_and_check (
  input logic        clk,
  input logic        rst,
  fcrc_in_if.sink    data_in,
  fcrc_out_if.source data_out
);
  import fcrc_pkg::*;

  in_word_t in_word;
  in_word_t word;
  logic     word_valid;
  logic     advance;

  assign in_word.op        = data_in.op;
  assign in_word.data_byte = data_in.data_byte;

  fcrc_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (data_in.valid),
    .in_ready   (data_in.ready),
    .in_word    (in_word),
    .word_valid (word_valid),
    .advance    (advance),
    .word       (word)
  );

  fcrc_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .word_valid (word_valid),
    .word       (word),
    .advance    (advance),
    .res_valid  (data_out.valid),
    .res_ready  (data_out.ready),
    .out_byte   (data_out.out_byte),
    .last       (data_out.last),
    .crc_ok     (data_out.crc_ok)
  );

endmodule

// ===== rtl/core/fcrc_in_reg.sv =====
// ----------------------------------------------------------------------------
// Frame CRC-16 input register
// Captures one input word per cycle and holds it while the engine stalls.
// ----------------------------------------------------------------------------
module fcrc_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  fcrc_pkg::in_word_t in_word,
  output logic              word_valid,
  input  logic              advance,
  output fcrc_pkg::in_word_t word
);
  import fcrc_pkg::*;

  assign in_ready = !word_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (in_ready) begin
      word_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      word <= in_word;
    end
  end

endmodule

// ===== rtl/core/fcrc_engine.sv =====
// ----------------------------------------------------------------------------
// Frame CRC-16 engine
// Tracks frame position and mode, updates the CRC and registers the result.
// ----------------------------------------------------------------------------
module fcrc_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               word_valid,
  input  fcrc_pkg::in_word_t word,
  output logic               advance,
  output logic               res_valid,
  input  logic               res_ready,
  output logic [7:0]         out_byte,
  output logic               last,
  output logic               crc_ok
);
  import fcrc_pkg::*;

  logic [15:0] running_crc;
  logic [15:0] running_crc_next;
  pos_t        byte_position;
  pos_t        byte_position_next;
  logic        frame_mode;
  logic        mode_cur;
  logic [7:0]  held_low_byte;
  logic [15:0] crc_cur;
  logic [7:0]  ob_next;
  logic        last_next;
  logic        ok_next;
  logic        fire;
  logic        in_span;
  logic        at_start;
  logic        at_lo;
  logic        at_hi;

  assign advance = !res_valid || res_ready;
  assign fire    = word_valid && advance;

  assign at_start = (byte_position == '0);
  assign at_lo    = (byte_position == POS_W'(LO_POS));
  assign at_hi    = (byte_position >= POS_W'(HI_POS));
  assign in_span  = (byte_position < POS_W'(LO_POS))
                 && ({1'b0, byte_position} >= (POS_W+1)'(CRC_FIRST_BYTE))
                 && ({1'b0, byte_position} < (POS_W+1)'(SPAN_END));

  assign mode_cur = at_start ? word.op : frame_mode;
  assign crc_cur  = at_start ? CRC_INIT : running_crc;

  always_comb begin
    running_crc_next   = crc_cur;
    ob_next            = word.data_byte;
    last_next          = 1'b0;
    ok_next            = 1'b1;
    byte_position_next = at_hi ? '0 : byte_position + 1'b1;
    if (in_span) begin
      running_crc_next = crc_byte(crc_cur, word.data_byte);
    end
    if (at_lo) begin
      if (mode_cur == OP_SEAL) begin
        ob_next = crc_cur[7:0];
      end
    end else if (at_hi) begin
      last_next = 1'b1;
      if (mode_cur == OP_SEAL) begin
        ob_next = crc_cur[15:8];
      end else begin
        ok_next = ({word.data_byte, held_low_byte} == crc_cur);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc   <= CRC_INIT;
      byte_position <= '0;
      frame_mode    <= OP_SEAL;
      held_low_byte <= '0;
      res_valid     <= 1'b0;
    end else begin
      if (advance) begin
        res_valid <= word_valid;
      end
      if (fire) begin
        running_crc   <= running_crc_next;
        byte_position <= byte_position_next;
        frame_mode    <= mode_cur;
        if (at_lo) begin
          held_low_byte <= word.data_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte <= ob_next;
      last     <= last_next;
      crc_ok   <= ok_next;
    end
  end

`ifndef ASSERT_OFF
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_position <= POS_W'(HI_POS))
    else $error("Frame position out of range.");

  a_last_follows_end: assert property (@(posedge clk) disable iff (rst)
    fire && at_hi |=> res_valid && last)
    else $error("End of frame did not produce a last result.");

  a_fail_only_check: assert property (@(posedge clk) disable iff (rst)
    res_valid && !crc_ok |-> last && (frame_mode == OP_CHECK))
    else $error("CRC failure flagged outside a check frame end.");

  a_wrap_after_end: assert property (@(posedge clk) disable iff (rst)
    fire && at_hi |=> byte_position == '0)
    else $error("Frame position did not wrap after the last byte.");
`endif

endmodule

// ===== verif/fcrc_frame_scoreboard.sv =====
// ----------------------------------------------------------------------------
// Frame CRC-16 scoreboard
// Watches both channels of the frame sealer, predicts every result word from
// the accepted input words and compares the words field by field, in order.
// ----------------------------------------------------------------------------
module fcrc_frame_scoreboard (
  input  logic clk,
  input  logic rst,
  fcrc_in_if   in_ch,
  fcrc_out_if  out_ch,
  output int   mismatches,
  output int   words_owed
);
  timeunit 1ns;
  timeprecision 1ps;
  import fcrc_pkg::*;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       crc_ok;
  } result_word_t;

  logic [15:0]  crc_table [256];
  logic [15:0]  frame_crc;
  int           frame_pos;
  logic         frame_op;
  logic [7:0]   held_lo;
  result_word_t result_words_q [$];
  int           result_index;

  function automatic logic [15:0] table_entry(input int idx);
    logic [15:0] v;
    v = 16'(idx);
    for (int k = 0; k < 8; k++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    end
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at result %0d: %0s", result_index, msg);
    mismatches++;
  endtask

  task automatic seal_or_check_byte(input logic op_b, input logic [7:0] b);
    result_word_t w;
    logic [15:0]  crc_now;
    w = '{out_byte: b, last: 1'b0, crc_ok: 1'b1};
    crc_now = frame_crc;
    if (frame_pos == 0) begin
      frame_op = op_b;
      crc_now = CRC_INIT;
    end
    if (frame_pos < LO_POS) begin
      if (frame_pos >= CRC_FIRST_BYTE && frame_pos < SPAN_END) begin
        crc_now = (crc_now >> 8) ^ crc_table[crc_now[7:0] ^ b];
      end
    end else if (frame_pos == LO_POS) begin
      held_lo = b;
      if (frame_op == OP_SEAL) begin
        w.out_byte = crc_now[7:0];
      end
    end else begin
      w.last = 1'b1;
      if (frame_op == OP_SEAL) begin
        w.out_byte = crc_now[15:8];
      end else begin
        w.crc_ok = ({b, held_lo} == crc_now);
      end
    end
    frame_crc = crc_now;
    frame_pos = (frame_pos >= HI_POS) ? 0 : frame_pos + 1;
    result_words_q.push_back(w);
  endtask

  initial begin
    mismatches = 0;
    words_owed = 0;
    result_index = 0;
    for (int i = 0; i < 256; i++) begin
      crc_table[i] = table_entry(i);
    end
  end

  always @(posedge clk) begin
    result_word_t want;
    if (rst) begin
      frame_crc = CRC_INIT;
      frame_pos = 0;
      frame_op = OP_SEAL;
      held_lo = 8'h00;
      result_words_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (result_words_q.size() == 0) begin
          report_mismatch("result word with no input word outstanding");
        end else begin
          want = result_words_q.pop_front();
          if (out_ch.out_byte !== want.out_byte) begin
            report_mismatch($sformatf("out_byte got %02h want %02h",
                                      out_ch.out_byte, want.out_byte));
          end
          if (out_ch.last !== want.last) begin
            report_mismatch($sformatf("last got %b want %b", out_ch.last, want.last));
          end
          if (out_ch.crc_ok !== want.crc_ok) begin
            report_mismatch($sformatf("crc_ok got %b want %b",
                                      out_ch.crc_ok, want.crc_ok));
          end
        end
        result_index++;
      end
      if (in_ch.valid && in_ch.ready) begin
        seal_or_check_byte(in_ch.op, in_ch.data_byte);
      end
    end
    words_owed <= result_words_q.size();
  end

endmodule

// ===== verif/tb_frame_crc16_seal_and_check.sv =====
// ----------------------------------------------------------------------------
// Frame CRC-16 seal and check testbench
// Sends whole frames in seal and check mode, with good and broken trailers,
// under random idling on both sides, and gives the verdict from the
// scoreboard's mismatch count.
// ----------------------------------------------------------------------------
module tb_frame_crc16_seal_and_check;
  timeunit 1ns;
  timeprecision 1ps;
  import fcrc_pkg::*;

  localparam int RANDOM_FRAMES  = 30;
  localparam int HOLD_FRAME     = 10;
  localparam int PAUSE_FRAME    = 18;
  localparam int QUIET_FRAME    = 26;
  localparam int RX_HOLD_CYCLES = 64;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 8;

  typedef enum int { FILL_ZERO, FILL_ONES, FILL_ALT, FILL_RANDOM } fill_t;
  typedef enum int { TR_GOOD, TR_FLIP, TR_RANDOM } trailer_t;

  logic clk;
  logic rst = 1'b1;
  logic rx_hold_req = 1'b0;
  logic rx_hold_done = 1'b0;
  logic tail_quiet = 1'b0;
  int   mismatches;
  int   words_owed;
  int   idle_cycles = 0;
  logic [7:0] frame_bytes [FRAME_BYTES];

  fcrc_in_if  in_ch();
  fcrc_out_if out_ch();

  frame_crc16_seal_and_check u_top (
    .clk      (clk),
    .rst      (rst),
    .data_in  (in_ch),
    .data_out (out_ch)
  );

  fcrc_frame_scoreboard u_scoreboard (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .mismatches (mismatches),
    .words_owed (words_owed)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  task automatic send_word(input logic op_b, input logic [7:0] b);
    in_ch.valid     <= 1'b1;
    in_ch.op        <= op_b;
    in_ch.data_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_frame(input logic op_b, input fill_t fill, input trailer_t trailer);
    logic [15:0] c;
    logic        word_op;
    c = CRC_INIT;
    for (int p = 0; p < FRAME_BYTES; p++) begin
      case (fill)
        FILL_ZERO: frame_bytes[p] = 8'h00;
        FILL_ONES: frame_bytes[p] = 8'hFF;
        FILL_ALT:  frame_bytes[p] = p[0] ? 8'hFF : 8'h00;
        default:   frame_bytes[p] = 8'($urandom_range(0, 255));
      endcase
    end
    for (int p = CRC_FIRST_BYTE; p < SPAN_END && p < LO_POS; p++) begin
      c ^= {8'h00, frame_bytes[p]};
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
    end
    if (trailer == TR_FLIP) begin
      c ^= 16'h0001 << $urandom_range(0, 15);
    end
    if (trailer != TR_RANDOM) begin
      frame_bytes[LO_POS] = c[7:0];
      frame_bytes[HI_POS] = c[15:8];
    end
    for (int p = 0; p < FRAME_BYTES; p++) begin
      if (!tail_quiet && !(rx_hold_req && !rx_hold_done) && $urandom_range(0, 9) == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      word_op = (p == 0) ? op_b : 1'($urandom_range(0, 1));
      send_word(word_op, frame_bytes[p]);
    end
  endtask

  initial begin : word_source
    logic     op_b;
    int       r;
    fill_t    fill;
    trailer_t trailer;
    in_ch.valid     <= 1'b0;
    in_ch.op        <= 1'b0;
    in_ch.data_byte <= 8'h00;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_frame(OP_CHECK, FILL_ALT, TR_GOOD);

    for (int f = 0; f < RANDOM_FRAMES; f++) begin
      if (f == HOLD_FRAME) begin
        rx_hold_req <= 1'b1;
      end
      if (f == PAUSE_FRAME) begin
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (words_owed != 0);
      end
      if (f == QUIET_FRAME) begin
        tail_quiet <= 1'b1;
      end
      op_b = 1'($urandom_range(0, 1));
      r = $urandom_range(0, 9);
      fill = (r == 0) ? FILL_ZERO : (r == 1) ? FILL_ONES : (r == 2) ? FILL_ALT : FILL_RANDOM;
      r = $urandom_range(0, 9);
      trailer = (r < 6) ? TR_GOOD : (r < 8) ? TR_FLIP : TR_RANDOM;
      send_frame(op_b, fill, trailer);
    end

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (words_owed != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : result_sink
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req && !rx_hold_done) begin
        out_ch.ready <= 1'b0;
        for (int n = 0; n < RX_HOLD_CYCLES; n++) begin
          @(posedge clk);
        end
        rx_hold_done <= 1'b1;
      end else if (!tail_quiet && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

endmodule

// ===== frame_crc16_seal_and_check.f =====
rtl/core/fcrc_pkg.sv
rtl/core/fcrc_if.sv
rtl/core/fcrc_in_reg.sv
rtl/core/fcrc_engine.sv
rtl/core/frame_crc16_seal_and_check.sv
verif/fcrc_frame_scoreboard.sv
verif/tb_frame_crc16_seal_and_check.sv
